// ===== rtl/pdl_pkg.sv =====
// Package for the pooled doubly linked list: widths, codes, control store and dispatch table.
package pdl_pkg;

  // Pool geometry and data width
  localparam int unsigned POOL_CELLS = 64;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned AW         = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1;
  // Index width holds POOL_CELLS itself, used as the "none" marker
  localparam int unsigned IX_W       = $clog2(POOL_CELLS + 1);

  // Fixed port widths
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned REQ_W      = 6;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IX_PORT_W  = 7;

  // Micro-address width
  localparam int unsigned UPC_W      = 5;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [IX_W-1:0]      ix_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [UPC_W-1:0]     upc_t;
  typedef logic [IX_PORT_W-1:0] ixp_t;
  typedef logic [VALUE_W-1:0]   valp_t;
  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [MODE_W-1:0]    mode_t;

  localparam ix_t  NONE_IX         = ix_t'(POOL_CELLS);
  localparam ixp_t NONE_PORT       = ixp_t'(POOL_CELLS);
  localparam ixp_t FULL_COUNT_PORT = ixp_t'(POOL_CELLS);

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_FRONT  = 3'd0,
    MODE_BACK   = 3'd1,
    MODE_AFTER  = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Branch conditions
  typedef enum logic [2:0] {
    C_NEXT   = 3'd0,
    C_ALWAYS = 3'd1,
    C_FULL   = 3'd2,
    C_BAD    = 3'd3,
    C_TAIL   = 3'd4
  } cond_e;

  // Link memory read address
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_FREE = 2'd1,
    RD_REQ  = 2'd2
  } rd_e;

  // Scratch link register load source
  typedef enum logic [2:0] {
    LK_KEEP = 3'd0,
    LK_HEAD = 3'd1,
    LK_TAIL = 3'd2,
    LK_REQ  = 3'd3,
    LK_NONE = 3'd4,
    LK_RD   = 3'd5
  } lk_e;

  // Link write address
  typedef enum logic [2:0] {
    WA_NONE = 3'd0,
    WA_C    = 3'd1,
    WA_HEAD = 3'd2,
    WA_TAIL = 3'd3,
    WA_REQ  = 3'd4,
    WA_LKNX = 3'd5,
    WA_LKPV = 3'd6
  } wa_e;

  // Link write data
  typedef enum logic [1:0] {
    WD_LKNX = 2'd0,
    WD_LKPV = 2'd1,
    WD_C    = 2'd2,
    WD_FREE = 2'd3
  } wd_e;

  // Head / tail pointer update
  typedef enum logic [1:0] {
    PT_KEEP       = 2'd0,
    PT_C          = 2'd1,
    PT_C_IF_EMPTY = 2'd2,
    PT_UNLINK     = 2'd3
  } ptr_e;

  // Result capture
  typedef enum logic [2:0] {
    RES_KEEP = 3'd0,
    RES_NEW  = 3'd1,
    RES_READ = 3'd2,
    RES_FULL = 3'd3,
    RES_BAD  = 3'd4,
    RES_NOP  = 3'd5
  } res_e;

  // One control word
  typedef struct packed {
    cond_e cond;
    upc_t  target;
    logic  done;
    rd_e   rd;
    logic  alloc;
    logic  pop;
    logic  cd_we;
    logic  free_cell;
    lk_e   nx_sel;
    lk_e   pv_sel;
    wa_e   nl_wa;
    wd_e   nl_wd;
    wa_e   pl_wa;
    wd_e   pl_wd;
    ptr_e  head_op;
    ptr_e  tail_op;
    res_e  res;
  } ctl_t;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic full;
    logic req_bad;
    logic is_tail;
  } flags_t;

  // Result bundle toward the output register
  typedef struct packed {
    status_e status;
    ixp_t    ix;
    valp_t   dv;
    ixp_t    nx;
    ixp_t    pv;
    ixp_t    head;
    ixp_t    tail;
    ixp_t    count;
  } res_t;

  // Micro-addresses
  localparam upc_t UA_FR_ALLOC = 5'd0;
  localparam upc_t UA_FR_LINK  = 5'd1;
  localparam upc_t UA_FR_FIX   = 5'd2;
  localparam upc_t UA_BK_ALLOC = 5'd3;
  localparam upc_t UA_BK_LINK  = 5'd4;
  localparam upc_t UA_BK_FIX   = 5'd5;
  localparam upc_t UA_AF_CHK   = 5'd6;
  localparam upc_t UA_AF_TAIL  = 5'd7;
  localparam upc_t UA_AF_ALLOC = 5'd8;
  localparam upc_t UA_AF_LINK  = 5'd9;
  localparam upc_t UA_AF_FIX   = 5'd10;
  localparam upc_t UA_RM_CHK   = 5'd11;
  localparam upc_t UA_RM_CAP   = 5'd12;
  localparam upc_t UA_RM_FIX   = 5'd13;
  localparam upc_t UA_RM_FREE  = 5'd14;
  localparam upc_t UA_RD_CHK   = 5'd15;
  localparam upc_t UA_RD_CAP   = 5'd16;
  localparam upc_t UA_FULL     = 5'd17;
  localparam upc_t UA_BAD      = 5'd18;
  localparam upc_t UA_NOP      = 5'd19;
  localparam upc_t UA_DONE     = 5'd20;

  // Dispatch table: entry point per operation
  function automatic upc_t mode_entry(mode_t m);
    upc_t a;
    a = UA_NOP;
    unique case (m)
      MODE_FRONT:  a = UA_FR_ALLOC;
      MODE_BACK:   a = UA_BK_ALLOC;
      MODE_AFTER:  a = UA_AF_CHK;
      MODE_REMOVE: a = UA_RM_CHK;
      MODE_READ:   a = UA_RD_CHK;
      default:     a = UA_NOP;
    endcase
    return a;
  endfunction

  // Control store
  function automatic ctl_t ucode(upc_t a);
    ctl_t w;
    w = '0;
    unique case (a)
      // Take a cell; new cell links to the old head
      UA_FR_ALLOC: begin
        w.alloc  = 1'b1;
        w.cond   = C_FULL;
        w.target = UA_FULL;
        w.rd     = RD_FREE;
        w.nx_sel = LK_HEAD;
        w.pv_sel = LK_NONE;
      end
      // Write the new cell's data and links, pop the free list if the cell came from it
      UA_FR_LINK, UA_BK_LINK, UA_AF_LINK: begin
        w.pop   = 1'b1;
        w.cd_we = 1'b1;
        w.nl_wa = WA_C;
        w.nl_wd = WD_LKNX;
        w.pl_wa = WA_C;
        w.pl_wd = WD_LKPV;
      end
      UA_FR_FIX: begin
        w.pl_wa   = WA_HEAD;
        w.pl_wd   = WD_C;
        w.head_op = PT_C;
        w.tail_op = PT_C_IF_EMPTY;
        w.res     = RES_NEW;
        w.cond    = C_ALWAYS;
        w.target  = UA_DONE;
      end
      UA_BK_ALLOC: begin
        w.alloc  = 1'b1;
        w.cond   = C_FULL;
        w.target = UA_FULL;
        w.rd     = RD_FREE;
        w.nx_sel = LK_NONE;
        w.pv_sel = LK_TAIL;
      end
      UA_BK_FIX: begin
        w.nl_wa   = WA_TAIL;
        w.nl_wd   = WD_C;
        w.tail_op = PT_C;
        w.head_op = PT_C_IF_EMPTY;
        w.res     = RES_NEW;
        w.cond    = C_ALWAYS;
        w.target  = UA_DONE;
      end
      UA_AF_CHK: begin
        w.cond   = C_BAD;
        w.target = UA_BAD;
      end
      // Anchor at the tail falls into the insert-at-back flow
      UA_AF_TAIL: begin
        w.cond   = C_TAIL;
        w.target = UA_BK_ALLOC;
        w.rd     = RD_REQ;
      end
      UA_AF_ALLOC: begin
        w.alloc  = 1'b1;
        w.cond   = C_FULL;
        w.target = UA_FULL;
        w.rd     = RD_FREE;
        w.nx_sel = LK_RD;
        w.pv_sel = LK_REQ;
      end
      UA_AF_FIX: begin
        w.nl_wa  = WA_REQ;
        w.nl_wd  = WD_C;
        w.pl_wa  = WA_LKNX;
        w.pl_wd  = WD_C;
        w.res    = RES_NEW;
        w.cond   = C_ALWAYS;
        w.target = UA_DONE;
      end
      UA_RM_CHK, UA_RD_CHK: begin
        w.cond   = C_BAD;
        w.target = UA_BAD;
        w.rd     = RD_REQ;
      end
      UA_RM_CAP: begin
        w.nx_sel = LK_RD;
        w.pv_sel = LK_RD;
        w.res    = RES_READ;
      end
      // Bridge the neighbors around the removed cell
      UA_RM_FIX: begin
        w.pl_wa   = WA_LKNX;
        w.pl_wd   = WD_LKPV;
        w.nl_wa   = WA_LKPV;
        w.nl_wd   = WD_LKNX;
        w.head_op = PT_UNLINK;
        w.tail_op = PT_UNLINK;
      end
      // Push the removed cell onto the free list
      UA_RM_FREE: begin
        w.nl_wa     = WA_REQ;
        w.nl_wd     = WD_FREE;
        w.free_cell = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = UA_DONE;
      end
      UA_RD_CAP: begin
        w.res    = RES_READ;
        w.cond   = C_ALWAYS;
        w.target = UA_DONE;
      end
      UA_FULL: begin
        w.res    = RES_FULL;
        w.cond   = C_ALWAYS;
        w.target = UA_DONE;
      end
      UA_BAD: begin
        w.res    = RES_BAD;
        w.cond   = C_ALWAYS;
        w.target = UA_DONE;
      end
      UA_NOP: begin
        w.res = RES_NOP;
      end
      UA_DONE: begin
        w.done = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = UA_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pooled_doubly_linked_list_unit.sv =====
// Transactions: a new one is accepted only after the previous one has finished, so one
//   runs at a time; the microprogram length per operation through the single-port link
//   memories sets how long each one runs.
// Reset: in-use bits cleared, head/tail/free list set to none, bump pointer and count
//   zeroed, all at once; cell memories are not cleared and no sweep runs.
// Top level of the pooled doubly linked list: handshake and result register.
module pooled_doubly_linked_list_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pdl_pkg::MODE_W-1:0]     mode_i,
  input  logic [pdl_pkg::REQ_W-1:0]      cell_req_i,
  input  logic [pdl_pkg::VALUE_W-1:0]    value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pdl_pkg::STATUS_W-1:0]   status_o,
  output logic [pdl_pkg::IX_PORT_W-1:0]  cell_index_o,
  output logic [pdl_pkg::VALUE_W-1:0]    cell_value_o,
  output logic [pdl_pkg::IX_PORT_W-1:0]  next_index_o,
  output logic [pdl_pkg::IX_PORT_W-1:0]  prev_index_o,
  output logic [pdl_pkg::IX_PORT_W-1:0]  head_index_o,
  output logic [pdl_pkg::IX_PORT_W-1:0]  tail_index_o,
  output logic [pdl_pkg::IX_PORT_W-1:0]  count_o
);

  logic             accept;
  logic             out_busy;
  logic             done;
  logic             out_valid_q;
  pdl_pkg::ctl_t    ctl;
  pdl_pkg::flags_t  flags;
  pdl_pkg::res_t    res;
  pdl_pkg::res_t    out_q;

  assign accept   = in_valid_i && in_ready_o;
  assign out_busy = out_valid_q && !out_ready_i;

  pdl_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .mode_i     (mode_i),
    .flags_i    (flags),
    .out_busy_i (out_busy),
    .ready_o    (in_ready_o),
    .done_o     (done),
    .ctl_o      (ctl)
  );

  pdl_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .cell_req_i (cell_req_i),
    .value_i    (value_i),
    .ctl_i      (ctl),
    .flags_o    (flags),
    .res_o      (res)
  );

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign cell_index_o = out_q.ix;
  assign cell_value_o = out_q.dv;
  assign next_index_o = out_q.nx;
  assign prev_index_o = out_q.pv;
  assign head_index_o = out_q.head;
  assign tail_index_o = out_q.tail;
  assign count_o      = out_q.count;

endmodule

// ===== rtl/pdl_sequencer.sv =====
// Micro-sequencer: step counter, control store lookup, conditional branches.
module pdl_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pdl_pkg::mode_t        mode_i,
  input  pdl_pkg::flags_t       flags_i,
  input  logic                  out_busy_i,
  output logic                  ready_o,
  output logic                  done_o,
  output pdl_pkg::ctl_t         ctl_o
);

  logic           busy_q, busy_d;
  pdl_pkg::upc_t  upc_q, upc_d;
  pdl_pkg::ctl_t  word;
  logic           taken;

  // Control word of the current step; all-quiet when idle
  always_comb begin
    word  = pdl_pkg::ucode(upc_q);
    ctl_o = busy_q ? word : '0;
  end

  // Branch condition
  always_comb begin
    unique case (word.cond)
      pdl_pkg::C_NEXT:   taken = 1'b0;
      pdl_pkg::C_ALWAYS: taken = 1'b1;
      pdl_pkg::C_FULL:   taken = flags_i.full;
      pdl_pkg::C_BAD:    taken = flags_i.req_bad;
      pdl_pkg::C_TAIL:   taken = flags_i.is_tail;
      default:           taken = 1'b0;
    endcase
  end

  assign ready_o = !busy_q;
  assign done_o  = busy_q && word.done && !out_busy_i;

  // Step counter
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        upc_d  = pdl_pkg::mode_entry(mode_i);
      end
    end else if (word.done) begin
      if (!out_busy_i) begin
        busy_d = 1'b0;
      end
    end else begin
      upc_d = taken ? word.target : upc_q + pdl_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

endmodule

// ===== rtl/pdl_datapath.sv =====
// Datapath: cell memories, list pointers, allocator state and result capture.
module pdl_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pdl_pkg::req_t    cell_req_i,
  input  pdl_pkg::valp_t   value_i,
  input  pdl_pkg::ctl_t    ctl_i,
  output pdl_pkg::flags_t  flags_o,
  output pdl_pkg::res_t    res_o
);

  // Latched operands
  pdl_pkg::req_t   req_q;
  pdl_pkg::data_t  val_q;

  // Cell memories and their registered read data
  pdl_pkg::data_t  cd_mem [pdl_pkg::POOL_CELLS];
  pdl_pkg::ix_t    nl_mem [pdl_pkg::POOL_CELLS];
  pdl_pkg::ix_t    pl_mem [pdl_pkg::POOL_CELLS];
  pdl_pkg::data_t  cd_rd_q;
  pdl_pkg::ix_t    nl_rd_q, pl_rd_q;

  // List and allocator state
  logic [pdl_pkg::POOL_CELLS-1:0] in_use_q, in_use_d;
  pdl_pkg::ix_t    head_q, head_d;
  pdl_pkg::ix_t    tail_q, tail_d;
  pdl_pkg::ix_t    free_q, free_d;
  pdl_pkg::ix_t    fresh_q, fresh_d;
  pdl_pkg::ix_t    count_q, count_d;
  logic            pop_q, pop_d;

  // Scratch: allocated cell and links of the cell being handled
  pdl_pkg::ix_t    c_q;
  pdl_pkg::ix_t    lk_nx_q, lk_pv_q;

  // Result registers
  pdl_pkg::status_e res_status_q;
  pdl_pkg::ixp_t    res_ix_q, res_nx_q, res_pv_q;
  pdl_pkg::valp_t   res_dv_q;

  pdl_pkg::ix_t    req_ix;
  pdl_pkg::addr_t  req_addr;
  logic            req_in_pool;
  logic            free_avail, full, alloc_go;
  pdl_pkg::ix_t    c_new;
  pdl_pkg::addr_t  rd_addr;
  pdl_pkg::ix_t    nl_wa, nl_wd, pl_wa, pl_wd;
  logic            nl_we, pl_we;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= cell_req_i;
      val_q <= pdl_pkg::data_t'(value_i);
    end
  end

  // Request checks and allocator choice
  always_comb begin
    req_ix      = pdl_pkg::ix_t'(req_q);
    req_addr    = pdl_pkg::addr_t'(req_q);
    req_in_pool = 32'(req_q) < pdl_pkg::POOL_CELLS;
    free_avail  = free_q != pdl_pkg::NONE_IX;
    full        = !free_avail && (fresh_q == pdl_pkg::NONE_IX);
    c_new       = free_avail ? free_q : fresh_q;
    alloc_go    = ctl_i.alloc && !full;
    rd_addr     = (ctl_i.rd == pdl_pkg::RD_FREE) ? pdl_pkg::addr_t'(free_q) : req_addr;
  end

  assign flags_o.full    = full;
  assign flags_o.req_bad = !(req_in_pool && in_use_q[req_addr]);
  assign flags_o.is_tail = req_ix == tail_q;

  // Next-link write port
  always_comb begin
    unique case (ctl_i.nl_wa)
      pdl_pkg::WA_C:    nl_wa = c_q;
      pdl_pkg::WA_HEAD: nl_wa = head_q;
      pdl_pkg::WA_TAIL: nl_wa = tail_q;
      pdl_pkg::WA_REQ:  nl_wa = req_ix;
      pdl_pkg::WA_LKNX: nl_wa = lk_nx_q;
      pdl_pkg::WA_LKPV: nl_wa = lk_pv_q;
      default:          nl_wa = pdl_pkg::NONE_IX;
    endcase
    unique case (ctl_i.nl_wd)
      pdl_pkg::WD_LKNX: nl_wd = lk_nx_q;
      pdl_pkg::WD_LKPV: nl_wd = lk_pv_q;
      pdl_pkg::WD_C:    nl_wd = c_q;
      pdl_pkg::WD_FREE: nl_wd = free_q;
      default:          nl_wd = pdl_pkg::NONE_IX;
    endcase
    nl_we = nl_wa < pdl_pkg::NONE_IX;
  end

  // Prev-link write port
  always_comb begin
    unique case (ctl_i.pl_wa)
      pdl_pkg::WA_C:    pl_wa = c_q;
      pdl_pkg::WA_HEAD: pl_wa = head_q;
      pdl_pkg::WA_TAIL: pl_wa = tail_q;
      pdl_pkg::WA_REQ:  pl_wa = req_ix;
      pdl_pkg::WA_LKNX: pl_wa = lk_nx_q;
      pdl_pkg::WA_LKPV: pl_wa = lk_pv_q;
      default:          pl_wa = pdl_pkg::NONE_IX;
    endcase
    unique case (ctl_i.pl_wd)
      pdl_pkg::WD_LKNX: pl_wd = lk_nx_q;
      pdl_pkg::WD_LKPV: pl_wd = lk_pv_q;
      pdl_pkg::WD_C:    pl_wd = c_q;
      pdl_pkg::WD_FREE: pl_wd = free_q;
      default:          pl_wd = pdl_pkg::NONE_IX;
    endcase
    pl_we = pl_wa < pdl_pkg::NONE_IX;
  end

  // Memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      nl_mem[pdl_pkg::addr_t'(nl_wa)] <= nl_wd;
    end
    if (pl_we) begin
      pl_mem[pdl_pkg::addr_t'(pl_wa)] <= pl_wd;
    end
    if (ctl_i.cd_we) begin
      cd_mem[pdl_pkg::addr_t'(c_q)] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd != pdl_pkg::RD_NONE) begin
      nl_rd_q <= nl_mem[rd_addr];
      pl_rd_q <= pl_mem[rd_addr];
      cd_rd_q <= cd_mem[rd_addr];
    end
  end

  // Allocator, free list and list pointers
  always_comb begin
    in_use_d = in_use_q;
    head_d   = head_q;
    tail_d   = tail_q;
    free_d   = free_q;
    fresh_d  = fresh_q;
    count_d  = count_q;
    pop_d    = pop_q;

    if (alloc_go) begin
      in_use_d[pdl_pkg::addr_t'(c_new)] = 1'b1;
      count_d = count_q + pdl_pkg::ix_t'(1);
      pop_d   = free_avail;
      if (!free_avail) begin
        fresh_d = fresh_q + pdl_pkg::ix_t'(1);
      end
    end
    if (ctl_i.pop && pop_q) begin
      free_d = nl_rd_q;
    end
    if (ctl_i.free_cell) begin
      in_use_d[req_addr] = 1'b0;
      count_d = count_q - pdl_pkg::ix_t'(1);
      free_d  = req_ix;
    end

    unique case (ctl_i.head_op)
      pdl_pkg::PT_KEEP: ;
      pdl_pkg::PT_C: head_d = c_q;
      pdl_pkg::PT_C_IF_EMPTY: begin
        if (head_q == pdl_pkg::NONE_IX) head_d = c_q;
      end
      pdl_pkg::PT_UNLINK: begin
        if (lk_pv_q == pdl_pkg::NONE_IX) head_d = lk_nx_q;
      end
      default: ;
    endcase

    unique case (ctl_i.tail_op)
      pdl_pkg::PT_KEEP: ;
      pdl_pkg::PT_C: tail_d = c_q;
      pdl_pkg::PT_C_IF_EMPTY: begin
        if (head_q == pdl_pkg::NONE_IX) tail_d = c_q;
      end
      pdl_pkg::PT_UNLINK: begin
        if (lk_nx_q == pdl_pkg::NONE_IX) tail_d = lk_pv_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      head_q   <= pdl_pkg::NONE_IX;
      tail_q   <= pdl_pkg::NONE_IX;
      free_q   <= pdl_pkg::NONE_IX;
      fresh_q  <= '0;
      count_q  <= '0;
      pop_q    <= 1'b0;
    end else begin
      in_use_q <= in_use_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      free_q   <= free_d;
      fresh_q  <= fresh_d;
      count_q  <= count_d;
      pop_q    <= pop_d;
    end
  end

  // Scratch registers
  always_ff @(posedge clk_i) begin
    if (alloc_go) begin
      c_q <= c_new;
    end
    unique case (ctl_i.nx_sel)
      pdl_pkg::LK_HEAD: lk_nx_q <= head_q;
      pdl_pkg::LK_TAIL: lk_nx_q <= tail_q;
      pdl_pkg::LK_REQ:  lk_nx_q <= req_ix;
      pdl_pkg::LK_NONE: lk_nx_q <= pdl_pkg::NONE_IX;
      pdl_pkg::LK_RD:   lk_nx_q <= nl_rd_q;
      default:          lk_nx_q <= lk_nx_q;
    endcase
    unique case (ctl_i.pv_sel)
      pdl_pkg::LK_HEAD: lk_pv_q <= head_q;
      pdl_pkg::LK_TAIL: lk_pv_q <= tail_q;
      pdl_pkg::LK_REQ:  lk_pv_q <= req_ix;
      pdl_pkg::LK_NONE: lk_pv_q <= pdl_pkg::NONE_IX;
      pdl_pkg::LK_RD:   lk_pv_q <= pl_rd_q;
      default:          lk_pv_q <= lk_pv_q;
    endcase
  end

  // Result capture
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.res)
      pdl_pkg::RES_NEW: begin
        res_status_q <= pdl_pkg::ST_OK;
        res_ix_q     <= pdl_pkg::ixp_t'(c_q);
        res_dv_q     <= pdl_pkg::valp_t'(val_q);
        res_nx_q     <= pdl_pkg::ixp_t'(lk_nx_q);
        res_pv_q     <= pdl_pkg::ixp_t'(lk_pv_q);
      end
      pdl_pkg::RES_READ: begin
        res_status_q <= pdl_pkg::ST_OK;
        res_ix_q     <= pdl_pkg::ixp_t'(req_q);
        res_dv_q     <= pdl_pkg::valp_t'(cd_rd_q);
        res_nx_q     <= pdl_pkg::ixp_t'(nl_rd_q);
        res_pv_q     <= pdl_pkg::ixp_t'(pl_rd_q);
      end
      pdl_pkg::RES_FULL: begin
        res_status_q <= pdl_pkg::ST_FULL;
        res_ix_q     <= pdl_pkg::NONE_PORT;
        res_dv_q     <= '0;
        res_nx_q     <= pdl_pkg::NONE_PORT;
        res_pv_q     <= pdl_pkg::NONE_PORT;
      end
      pdl_pkg::RES_BAD: begin
        res_status_q <= pdl_pkg::ST_BAD;
        res_ix_q     <= pdl_pkg::ixp_t'(req_q);
        res_dv_q     <= '0;
        res_nx_q     <= pdl_pkg::NONE_PORT;
        res_pv_q     <= pdl_pkg::NONE_PORT;
      end
      pdl_pkg::RES_NOP: begin
        res_status_q <= pdl_pkg::ST_OK;
        res_ix_q     <= pdl_pkg::NONE_PORT;
        res_dv_q     <= '0;
        res_nx_q     <= pdl_pkg::NONE_PORT;
        res_pv_q     <= pdl_pkg::NONE_PORT;
      end
      default: ;
    endcase
  end

  assign res_o.status = res_status_q;
  assign res_o.ix     = res_ix_q;
  assign res_o.dv     = res_dv_q;
  assign res_o.nx     = res_nx_q;
  assign res_o.pv     = res_pv_q;
  assign res_o.head   = pdl_pkg::ixp_t'(head_q);
  assign res_o.tail   = pdl_pkg::ixp_t'(tail_q);
  assign res_o.count  = pdl_pkg::ixp_t'(count_q);

endmodule

// ===== rtl/pdl_checker.sv =====
// Port-level checker for the pooled doubly linked list unit, with its bind.
module pdl_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  logic [pdl_pkg::MODE_W-1:0]     mode_i,
  input  logic [pdl_pkg::REQ_W-1:0]      cell_req_i,
  input  logic [pdl_pkg::VALUE_W-1:0]    value_i,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [pdl_pkg::STATUS_W-1:0]   status_o,
  input  logic [pdl_pkg::IX_PORT_W-1:0]  cell_index_o,
  input  logic [pdl_pkg::VALUE_W-1:0]    cell_value_o,
  input  logic [pdl_pkg::IX_PORT_W-1:0]  next_index_o,
  input  logic [pdl_pkg::IX_PORT_W-1:0]  prev_index_o,
  input  logic [pdl_pkg::IX_PORT_W-1:0]  head_index_o,
  input  logic [pdl_pkg::IX_PORT_W-1:0]  tail_index_o,
  input  logic [pdl_pkg::IX_PORT_W-1:0]  count_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(cell_index_o) && $stable(cell_value_o) && $stable(count_o))
    else $error("result changed while stalled");

  // One operation in flight: no transaction right after an accepted one
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an operation runs");

  // Empty list: count zero, head and tail both none
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((count_o == '0) == (head_index_o == pdl_pkg::NONE_PORT)) &&
      ((head_index_o == pdl_pkg::NONE_PORT) == (tail_index_o == pdl_pkg::NONE_PORT)))
    else $error("head, tail and count disagree");

  // Pool full only when every cell is in the list
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pdl_pkg::ST_FULL |->
      cell_index_o == pdl_pkg::NONE_PORT && count_o == pdl_pkg::FULL_COUNT_PORT)
    else $error("pool full reported with free cells");

endmodule

bind pooled_doubly_linked_list_unit pdl_checker u_pdl_checker (.*);

// ===== tb/pdl_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the pooled list unit: mirrors the list, predicts each result and compares it.
module pdl_list_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [pdl_pkg::MODE_W-1:0]         mode_i,
  input  logic [pdl_pkg::REQ_W-1:0]          cell_req_i,
  input  logic [pdl_pkg::VALUE_W-1:0]        value_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [pdl_pkg::STATUS_W-1:0]       status_i,
  input  logic [pdl_pkg::IX_PORT_W-1:0]      cell_index_i,
  input  logic [pdl_pkg::VALUE_W-1:0]        cell_value_i,
  input  logic [pdl_pkg::IX_PORT_W-1:0]      next_index_i,
  input  logic [pdl_pkg::IX_PORT_W-1:0]      prev_index_i,
  input  logic [pdl_pkg::IX_PORT_W-1:0]      head_index_i,
  input  logic [pdl_pkg::IX_PORT_W-1:0]      tail_index_i,
  input  logic [pdl_pkg::IX_PORT_W-1:0]      count_i,
  output int unsigned                        mismatches_o,
  output int unsigned                        pending_o,
  output logic [pdl_pkg::POOL_CELLS-1:0]     live_cells_o
);
  import pdl_pkg::*;

  localparam ixp_t NIL = NONE_PORT;

  // Shadow copy of the pool and list pointers
  valp_t                 cell_word [POOL_CELLS];
  ixp_t                  fwd_link  [POOL_CELLS];
  ixp_t                  back_link [POOL_CELLS];
  logic [POOL_CELLS-1:0] live_q;
  ixp_t                  head_q;
  ixp_t                  tail_q;
  ixp_t                  free_q;
  ixp_t                  fresh_q;
  ixp_t                  count_q;

  res_t        awaited_results[$];
  int unsigned seen_results   = 0;
  int unsigned mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  // Allocation: free list first, then the bump pointer; NIL when the pool is exhausted
  function automatic ixp_t take_free_cell();
    ixp_t c;
    if (free_q != NIL) begin
      c      = free_q;
      free_q = fwd_link[addr_t'(c)];
    end else if (fresh_q != NIL) begin
      c       = fresh_q;
      fresh_q = fresh_q + 1'b1;
    end else begin
      return NIL;
    end
    live_q[addr_t'(c)] = 1'b1;
    count_q = count_q + 1'b1;
    return c;
  endfunction

  function automatic ixp_t link_front(valp_t v);
    ixp_t c;
    c = take_free_cell();
    if (c == NIL) return NIL;
    cell_word[addr_t'(c)] = v;
    if (head_q == NIL) tail_q = c;
    else back_link[addr_t'(head_q)] = c;
    back_link[addr_t'(c)] = NIL;
    fwd_link[addr_t'(c)]  = head_q;
    head_q = c;
    return c;
  endfunction

  function automatic ixp_t link_back(valp_t v);
    ixp_t c;
    c = take_free_cell();
    if (c == NIL) return NIL;
    cell_word[addr_t'(c)] = v;
    if (tail_q == NIL) head_q = c;
    else fwd_link[addr_t'(tail_q)] = c;
    fwd_link[addr_t'(c)]  = NIL;
    back_link[addr_t'(c)] = tail_q;
    tail_q = c;
    return c;
  endfunction

  // Anchor at the tail degenerates into an append
  function automatic ixp_t link_after(ixp_t anchor, valp_t v);
    ixp_t c;
    ixp_t succ;
    if (anchor == tail_q) return link_back(v);
    c = take_free_cell();
    if (c == NIL) return NIL;
    cell_word[addr_t'(c)] = v;
    succ = fwd_link[addr_t'(anchor)];
    fwd_link[addr_t'(c)] = succ;
    if (succ != NIL) back_link[addr_t'(succ)] = c;
    back_link[addr_t'(c)]     = anchor;
    fwd_link[addr_t'(anchor)] = c;
    return c;
  endfunction

  // Bridge the neighbors, then push the cell onto the free list
  function automatic void unlink_cell(addr_t c);
    ixp_t nx;
    ixp_t pv;
    nx = fwd_link[c];
    pv = back_link[c];
    if (nx != NIL) back_link[addr_t'(nx)] = pv;
    else tail_q = pv;
    if (pv != NIL) fwd_link[addr_t'(pv)] = nx;
    else head_q = nx;
    fwd_link[c] = free_q;
    free_q      = ixp_t'(c);
    live_q[c]   = 1'b0;
    count_q     = count_q - 1'b1;
  endfunction

  // One operation against the shadow list; returns the result the unit should give
  function automatic res_t apply_list_op(mode_t m, req_t r, valp_t v);
    res_t e;
    ixp_t c;
    logic req_live;
    req_live = live_q[r];
    e.status = ST_OK;
    e.ix     = NIL;
    e.dv     = '0;
    e.nx     = NIL;
    e.pv     = NIL;
    case (m)
      MODE_FRONT, MODE_BACK, MODE_AFTER: begin
        if (m == MODE_AFTER && !req_live) begin
          e.status = ST_BAD;
          e.ix     = ixp_t'(r);
        end else begin
          if (m == MODE_FRONT) c = link_front(v);
          else if (m == MODE_BACK) c = link_back(v);
          else c = link_after(ixp_t'(r), v);
          if (c == NIL) begin
            e.status = ST_FULL;
          end else begin
            e.ix = c;
            e.dv = cell_word[addr_t'(c)];
            e.nx = fwd_link[addr_t'(c)];
            e.pv = back_link[addr_t'(c)];
          end
        end
      end
      MODE_REMOVE, MODE_READ: begin
        e.ix = ixp_t'(r);
        if (!req_live) begin
          e.status = ST_BAD;
        end else begin
          // links are reported as they were before any removal
          e.dv = cell_word[r];
          e.nx = fwd_link[r];
          e.pv = back_link[r];
          if (m == MODE_REMOVE) unlink_cell(r);
        end
      end
      default: ;
    endcase
    e.head  = head_q;
    e.tail  = tail_q;
    e.count = count_q;
    return e;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_total++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                seen_results, name, got, want));
  endtask

  // Compare an accepted result against the oldest prediction
  task automatic check_result();
    res_t want;
    seen_results++;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                seen_results));
      return;
    end
    want = awaited_results.pop_front();
    check_field("status",     32'(status_i),     32'(want.status));
    check_field("cell_index", 32'(cell_index_i), 32'(want.ix));
    check_field("cell_value", 32'(cell_value_i), 32'(want.dv));
    check_field("next_index", 32'(next_index_i), 32'(want.nx));
    check_field("prev_index", 32'(prev_index_i), 32'(want.pv));
    check_field("head_index", 32'(head_index_i), 32'(want.head));
    check_field("tail_index", 32'(tail_index_i), 32'(want.tail));
    check_field("count",      32'(count_i),      32'(want.count));
  endtask

  // Channel monitor; exported views are registered so readers at the edge see settled values
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  = '0;
      head_q  = NIL;
      tail_q  = NIL;
      free_q  = NIL;
      fresh_q = '0;
      count_q = '0;
      awaited_results.delete();
      pending_o    <= 0;
      live_cells_o <= '0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(apply_list_op(mode_t'(mode_i), req_t'(cell_req_i),
                                                valp_t'(value_i)));
      pending_o    <= awaited_results.size();
      live_cells_o <= live_q;
    end
  end

endmodule

// ===== tb/tb_pooled_doubly_linked_list_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the pooled list unit: clock, reset, directed and random stimulus, verdict.
module tb_pooled_doubly_linked_list_unit;
  import pdl_pkg::*;

  localparam int PHASE_ITEMS  = 250;
  localparam int SND_IDLE_PCT = 34;
  localparam int RCV_IDLE_PCT = 45;
  localparam int DRAIN_CYCLES = 12;
  localparam int LIMIT_NS     = 2_000_000;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [MODE_W-1:0]    mode_i       = '0;
  logic [REQ_W-1:0]     cell_req_i   = '0;
  logic [VALUE_W-1:0]   value_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [IX_PORT_W-1:0] cell_index_o;
  logic [VALUE_W-1:0]   cell_value_o;
  logic [IX_PORT_W-1:0] next_index_o;
  logic [IX_PORT_W-1:0] prev_index_o;
  logic [IX_PORT_W-1:0] head_index_o;
  logic [IX_PORT_W-1:0] tail_index_o;
  logic [IX_PORT_W-1:0] count_o;

  int unsigned           mismatches;
  int unsigned           pending;
  logic [POOL_CELLS-1:0] live_cells;

  int snd_idle_pct = SND_IDLE_PCT;
  int rcv_idle_pct = RCV_IDLE_PCT;

  pooled_doubly_linked_list_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .cell_req_i   (cell_req_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .cell_index_o (cell_index_o),
    .cell_value_o (cell_value_o),
    .next_index_o (next_index_o),
    .prev_index_o (prev_index_o),
    .head_index_o (head_index_o),
    .tail_index_o (tail_index_o),
    .count_o      (count_o)
  );

  pdl_list_checker list_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .cell_req_i   (cell_req_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .cell_index_i (cell_index_o),
    .cell_value_i (cell_value_o),
    .next_index_i (next_index_o),
    .prev_index_i (prev_index_o),
    .head_index_i (head_index_o),
    .tail_index_i (tail_index_o),
    .count_i      (count_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .live_cells_o (live_cells)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Present one transaction, with random idle cycles ahead of it, and hold until accepted
  task automatic send_item(mode_t m, req_t r, valp_t v);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    cell_req_i <= r;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic req_t pick_live(int n);
    int k;
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < POOL_CELLS; i++) begin
      if (live_cells[i]) begin
        if (k == 0) return req_t'(i);
        k--;
      end
    end
    return '0;
  endfunction

  // Random traffic that tides between filling the pool and draining it
  task automatic send_random(inout bit growing);
    int    n;
    int    roll;
    mode_t m;
    req_t  r;
    n = $countones(live_cells);
    if (growing && n == POOL_CELLS && $urandom_range(0, 3) == 0) growing = 1'b0;
    else if (!growing && n == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
    roll = $urandom_range(0, 99);
    if (roll >= 97)
      m = mode_t'($urandom_range(int'(MODE_READ) + 1, (1 << MODE_W) - 1));
    else if (growing)
      m = roll < 30 ? MODE_FRONT : roll < 60 ? MODE_BACK : roll < 80 ? MODE_AFTER :
          roll < 88 ? MODE_REMOVE : MODE_READ;
    else
      m = roll < 5 ? MODE_FRONT : roll < 10 ? MODE_BACK : roll < 15 ? MODE_AFTER :
          roll < 85 ? MODE_REMOVE : MODE_READ;
    if (n > 0 && $urandom_range(0, 99) < 88) r = pick_live(n);
    else r = req_t'($urandom_range(0, POOL_CELLS - 1));
    send_item(m, r, valp_t'($urandom));
  endtask

  // Stimulus and verdict
  initial begin
    bit growing;
    growing = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list: every cell reference is rejected, undefined modes do nothing
    send_item(MODE_READ,   6'd0,  32'h0000_0000);
    send_item(MODE_REMOVE, 6'd63, 32'hFFFF_FFFF);
    send_item(MODE_AFTER,  6'd5,  32'h1234_5678);
    for (int k = 1; k <= 3; k++)
      send_item(mode_t'(int'(MODE_READ) + k), req_t'(k), 32'hFFFF_FFFF);

    // build a short list: front, back, after a middle cell, after the tail
    send_item(MODE_FRONT, 6'd0, 32'h0000_0000);
    send_item(MODE_BACK,  6'd0, 32'hFFFF_FFFF);
    send_item(MODE_FRONT, 6'd0, 32'hA5A5_A5A5);
    send_item(MODE_AFTER, 6'd0, 32'h5A5A_5A5A);
    send_item(MODE_AFTER, 6'd1, 32'h0000_0001);
    send_item(MODE_READ,  6'd3, 32'h0000_0000);

    // remove middle, head and tail, then reuse a freed cell
    send_item(MODE_REMOVE, 6'd3, 32'h0000_0000);
    send_item(MODE_REMOVE, 6'd2, 32'h0000_0000);
    send_item(MODE_REMOVE, 6'd4, 32'h0000_0000);
    send_item(MODE_BACK,   6'd0, 32'h8000_0000);
    send_item(MODE_READ,   6'd3, 32'h0000_0000);
    send_item(MODE_AFTER,  6'd2, 32'h0000_0000);

    // empty the list completely, then restart from the free list
    send_item(MODE_REMOVE, 6'd0, 32'h0000_0000);
    send_item(MODE_REMOVE, 6'd4, 32'h0000_0000);
    send_item(MODE_REMOVE, 6'd1, 32'h0000_0000);
    send_item(MODE_FRONT,  6'd0, 32'h7FFF_FFFF);
    send_item(MODE_AFTER,  6'd1, 32'hDEAD_BEEF);
    wait_drained();

    // sender idles 34 percent, receiver 45
    for (int i = 0; i < PHASE_ITEMS; i++) send_random(growing);
    wait_drained();

    // roles swapped
    snd_idle_pct <= RCV_IDLE_PCT;
    rcv_idle_pct <= SND_IDLE_PCT;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random(growing);
    wait_drained();

    // full rate on both sides
    snd_idle_pct <= 0;
    rcv_idle_pct <= 0;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random(growing);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_pooled_doubly_linked_list_unit passed");
    end else begin
      $display("tb_pooled_doubly_linked_list_unit failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_NS;
    $display("tb_pooled_doubly_linked_list_unit failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pdl_pkg.sv
rtl/pdl_sequencer.sv
rtl/pdl_datapath.sv
rtl/pooled_doubly_linked_list_unit.sv
rtl/pdl_checker.sv
tb/pdl_list_checker.sv
tb/tb_pooled_doubly_linked_list_unit.sv
